[sv/glb3_pkg.sv]
// Shared constants and types for the 3x3 Gaussian blur block.
package glb3_pkg;

  localparam int unsigned PIX_W            = 8;
  localparam int unsigned POS_W            = 11;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 12;
  localparam int unsigned SUM_W            = 12;
  localparam int unsigned SUM_SHIFT        = 4;
  localparam int unsigned MIN_SIZE         = 3;
  localparam int unsigned DEF_MAX_WIDTH    = 2048;
  localparam int unsigned DEF_MAX_HEIGHT   = 2048;
  localparam int unsigned DEF_IMAGE_WIDTH  = 640;
  localparam int unsigned DEF_IMAGE_HEIGHT = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic has_result;
    logic frame_last;
  } pos_flags_t;

endpackage

[sv/glb3_if.sv]
// Channel interfaces for pixel input, blurred output and configuration writes.
interface glb3_in_if import glb3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             frame_start;

  modport source(output valid, pixel_in, frame_start, input ready);
  modport sink(input valid, pixel_in, frame_start, output ready);
endinterface

interface glb3_out_if import glb3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] filtered_pixel;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic             frame_end;

  modport source(output valid, filtered_pixel, out_row, out_col, frame_end, input ready);
  modport sink(input valid, filtered_pixel, out_row, out_col, frame_end, output ready);
endinterface

interface glb3_cfg_if import glb3_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source(output valid, idx, wdata, input ready);
  modport sink(input valid, idx, wdata, output ready);
endinterface

[sv/glb3_linebuf.sv]
// Two-line pixel buffer: one memory word per column holding the upper and middle lines.
module glb3_linebuf import glb3_pkg::*; #(
  parameter int unsigned DEPTH = DEF_MAX_WIDTH,
  parameter int unsigned AW    = $clog2(DEF_MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_upper,
  input  logic [PIX_W-1:0] wr_middle,
  output logic [PIX_W-1:0] rd_upper,
  output logic [PIX_W-1:0] rd_middle
);

  logic [2*PIX_W-1:0] mem_r [DEPTH];
  logic [2*PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_upper, wr_middle};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_upper  = rd_data_r[2*PIX_W-1:PIX_W];
  assign rd_middle = rd_data_r[PIX_W-1:0];

endmodule

[sv/glb3_window.sv]
// Six-entry window over the two previous columns and the 1-2-1 weighted sum.
module glb3_window import glb3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  logic [PIX_W-1:0] top,
  input  logic [PIX_W-1:0] mid,
  input  logic [PIX_W-1:0] pix,
  output logic [PIX_W-1:0] blur
);

  logic [PIX_W-1:0] win_r [6];
  logic [SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift_en) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= pix;
    end
  end

  always_comb begin
    sum = SUM_W'(win_r[0]) + (SUM_W'(win_r[3]) << 1) + SUM_W'(top)
        + (SUM_W'(win_r[1]) << 1) + (SUM_W'(win_r[4]) << 2) + (SUM_W'(mid) << 1)
        + SUM_W'(win_r[2]) + (SUM_W'(win_r[5]) << 1) + SUM_W'(pix);
  end

  assign blur = sum[SUM_W-1:SUM_SHIFT];

endmodule

[sv/glb3_ctrl.sv]
// Image size registers and the column and row counters of the incoming pixel.
module glb3_ctrl import glb3_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned XW         = $clog2(DEF_MAX_WIDTH),
  parameter int unsigned YW         = $clog2(DEF_MAX_HEIGHT)
) (
  input  logic            clk,
  input  logic            rst_n,
  glb3_cfg_if.sink        cfg_chan,
  input  logic            accept,
  input  logic            frame_start,
  output logic [XW-1:0]   cur_col,
  output logic [YW-1:0]   cur_row,
  output pos_flags_t      cur_flags
);

  localparam int unsigned SWW = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ?
                                $clog2(MAX_WIDTH + 1) : CFG_DATA_W;
  localparam int unsigned SWH = ($clog2(MAX_HEIGHT + 1) > CFG_DATA_W) ?
                                $clog2(MAX_HEIGHT + 1) : CFG_DATA_W;
  localparam int unsigned W_RESET = (DEF_IMAGE_WIDTH > MAX_WIDTH) ?
                                    MAX_WIDTH : DEF_IMAGE_WIDTH;
  localparam int unsigned H_RESET = (DEF_IMAGE_HEIGHT > MAX_HEIGHT) ?
                                    MAX_HEIGHT : DEF_IMAGE_HEIGHT;

  logic [SWW-1:0] width_r;
  logic [SWH-1:0] height_r;
  logic [XW-1:0]  col_r;
  logic [YW-1:0]  row_r;
  logic [XW-1:0]  col_nxt;
  logic [YW-1:0]  row_nxt;
  logic [SWW-1:0] wdata_w;
  logic [SWH-1:0] wdata_h;
  logic [SWW-1:0] width_clamp;
  logic [SWH-1:0] height_clamp;
  logic [SWW-1:0] col_ext;
  logic [SWH-1:0] row_ext;
  logic           col_wrap;
  logic           row_wrap;

  assign cfg_chan.ready = 1'b1;

  // Out-of-range sizes saturate to the supported range when written.
  always_comb begin
    wdata_w = SWW'(cfg_chan.wdata);
    wdata_h = SWH'(cfg_chan.wdata);
    if (wdata_w < SWW'(MIN_SIZE)) begin
      width_clamp = SWW'(MIN_SIZE);
    end else if (wdata_w > SWW'(MAX_WIDTH)) begin
      width_clamp = SWW'(MAX_WIDTH);
    end else begin
      width_clamp = wdata_w;
    end
    if (wdata_h < SWH'(MIN_SIZE)) begin
      height_clamp = SWH'(MIN_SIZE);
    end else if (wdata_h > SWH'(MAX_HEIGHT)) begin
      height_clamp = SWH'(MAX_HEIGHT);
    end else begin
      height_clamp = wdata_h;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SWW'(W_RESET);
      height_r <= SWH'(H_RESET);
    end else if (cfg_chan.valid) begin
      if (cfg_chan.idx == REG_IMAGE_WIDTH) begin
        width_r <= width_clamp;
      end
      if (cfg_chan.idx == REG_IMAGE_HEIGHT) begin
        height_r <= height_clamp;
      end
    end
  end

  always_comb begin
    cur_col  = frame_start ? '0 : col_r;
    cur_row  = frame_start ? '0 : row_r;
    col_ext  = SWW'(cur_col);
    row_ext  = SWH'(cur_row);
    col_wrap = (col_ext + SWW'(1)) >= width_r;
    row_wrap = (row_ext + SWH'(1)) >= height_r;

    cur_flags.has_result = (row_ext >= SWH'(2)) && (col_ext >= SWW'(2)) &&
                           (row_ext < height_r) && (col_ext < width_r);
    cur_flags.frame_last = (row_ext == height_r - SWH'(1)) &&
                           (col_ext == width_r - SWW'(1));

    if (col_wrap) begin
      col_nxt = '0;
      row_nxt = row_wrap ? '0 : cur_row + YW'(1);
    end else begin
      col_nxt = cur_col + XW'(1);
      row_nxt = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

[sv/gaussian_blur_3x3_gray.sv]
// Top level of the streaming 3x3 Gaussian blur for 8-bit gray images.
//
//   channel   direction  payload                                        transfer
//   in_chan   sink       pixel_in, frame_start                          valid & ready
//   out_chan  source     filtered_pixel, out_row, out_col, frame_end    valid & ready
//   cfg_chan  sink       idx, wdata (0 = image_width, 1 = image_height) valid & ready
//
// One pixel is taken every cycle unless the output stalls; after its pixel's transfer a result
// passes the line buffer read, captured with the stage 1 registers, and then the output register.
// Reset sets the sizes to 640 by 480 and clears the counters and the window; the line
// buffer memory is not cleared and holds no valid data until written.
// A stall on the output holds the stage behind it; once that stage is occupied,
// in_chan.ready drops in the same cycle.
// The configuration port is always ready.
module gaussian_blur_3x3_gray import glb3_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  glb3_in_if.sink    in_chan,
  glb3_out_if.source out_chan,
  glb3_cfg_if.sink   cfg_chan
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);

  logic             in_accept;
  logic             s1_adv;
  logic             s1_valid_r;
  logic [XW-1:0]    s1_col_r;
  logic [YW-1:0]    s1_row_r;
  pos_flags_t       s1_flags_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [XW-1:0]    cur_col;
  logic [YW-1:0]    cur_row;
  pos_flags_t       cur_flags;
  logic [PIX_W-1:0] top;
  logic [PIX_W-1:0] mid;
  logic [PIX_W-1:0] blur;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic [POS_W-1:0] out_row_r;
  logic [POS_W-1:0] out_col_r;
  logic             out_end_r;

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_accept     = in_chan.valid && in_chan.ready;

  glb3_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .XW        (XW),
    .YW        (YW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_chan   (cfg_chan),
    .accept     (in_accept),
    .frame_start(in_chan.frame_start),
    .cur_col    (cur_col),
    .cur_row    (cur_row),
    .cur_flags  (cur_flags)
  );

  glb3_linebuf #(
    .DEPTH(MAX_WIDTH),
    .AW   (XW)
  ) u_linebuf (
    .clk      (clk),
    .rd_en    (in_accept),
    .rd_addr  (cur_col),
    .wr_en    (s1_adv),
    .wr_addr  (s1_col_r),
    .wr_upper (mid),
    .wr_middle(s1_pix_r),
    .rd_upper (top),
    .rd_middle(mid)
  );

  glb3_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .shift_en(s1_adv),
    .top     (top),
    .mid     (mid),
    .pix     (s1_pix_r),
    .blur    (blur)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col_r   <= cur_col;
      s1_row_r   <= cur_row;
      s1_flags_r <= cur_flags;
      s1_pix_r   <= in_chan.pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_flags_r.has_result;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pix_r <= blur;
      out_row_r <= POS_W'(s1_row_r - YW'(1));
      out_col_r <= POS_W'(s1_col_r - XW'(1));
      out_end_r <= s1_flags_r.frame_last;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.filtered_pixel = out_pix_r;
  assign out_chan.out_row        = out_row_r;
  assign out_chan.out_col        = out_col_r;
  assign out_chan.frame_end      = out_end_r;

`ifndef SYNTHESIS
  a_ready_low_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (s1_valid_r && out_valid_r))
    else $error("input ready low while the pipeline has room");

  a_result_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_flags_r.has_result) |=> out_valid_r)
    else $error("interior pixel result did not reach the output register");

  a_result_interior: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_flags_r.has_result) |-> (s1_col_r >= XW'(2) && s1_row_r >= YW'(2)))
    else $error("result flagged for a border pixel");

  a_out_position_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_row_r != '0 && out_col_r != '0))
    else $error("output position lies on the first row or column");
`endif

endmodule

[bench/tb_gaussian_blur_3x3_gray.sv]
// Self-checking testbench for the streaming 3x3 Gaussian blur of gray pixel frames.
`timescale 1ns / 100ps

module tb_gaussian_blur_3x3_gray;
  import glb3_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } blur_result_t;

  class blur_scoreboard;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [PIX_W-1:0]      upper_line [DEF_MAX_WIDTH];
    logic [PIX_W-1:0]      middle_line [DEF_MAX_WIDTH];
    logic [PIX_W-1:0]      taps [6];
    int unsigned           col_pos;
    int unsigned           row_pos;
    blur_result_t          expected_blurs [$];
    int unsigned           error_count;

    function new();
      width_reg = DEF_IMAGE_WIDTH;
      height_reg = DEF_IMAGE_HEIGHT;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      foreach (taps[i]) taps[i] = '0;
      col_pos = 0;
      row_pos = 0;
      error_count = 0;
    endfunction

    function int unsigned clamp_size(logic [CFG_DATA_W-1:0] v, int unsigned maxv);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_IMAGE_WIDTH: width_reg = value;
        REG_IMAGE_HEIGHT: height_reg = value;
        default: ;
      endcase
    endfunction

    function int unsigned frame_pixels();
      return clamp_size(width_reg, DEF_MAX_WIDTH) * clamp_size(height_reg, DEF_MAX_HEIGHT);
    endfunction

    function int unsigned pending();
      return expected_blurs.size();
    endfunction

    function void take_pixel(logic [PIX_W-1:0] pix, logic fs);
      int unsigned  w;
      int unsigned  h;
      int unsigned  c;
      int unsigned  r;
      int unsigned  top;
      int unsigned  mid;
      int unsigned  sum;
      blur_result_t res;
      w = clamp_size(width_reg, DEF_MAX_WIDTH);
      h = clamp_size(height_reg, DEF_MAX_HEIGHT);
      if (fs) begin
        col_pos = 0;
        row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      top = upper_line[c];
      mid = middle_line[c];
      if (r >= 2 && c >= 2 && r < h && c < w) begin
        sum = taps[0] + 2 * taps[3] + top
            + 2 * taps[1] + 4 * taps[4] + 2 * mid
            + taps[2] + 2 * taps[5] + pix;
        res.pixel = PIX_W'(sum >> SUM_SHIFT);
        res.row = POS_W'(r - 1);
        res.col = POS_W'(c - 1);
        res.last = (r == h - 1 && c == w - 1);
        expected_blurs.push_back(res);
      end
      taps[0] = taps[3];
      taps[1] = taps[4];
      taps[2] = taps[5];
      taps[3] = PIX_W'(top);
      taps[4] = PIX_W'(mid);
      taps[5] = pix;
      upper_line[c] = PIX_W'(mid);
      middle_line[c] = pix;
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_blurred(logic [PIX_W-1:0] pix, logic [POS_W-1:0] row,
                                logic [POS_W-1:0] col, logic fe);
      blur_result_t want;
      if (expected_blurs.size() == 0) begin
        $error("unexpected result: filtered_pixel %0d out_row %0d out_col %0d frame_end %0d",
               pix, row, col, fe);
        error_count++;
        return;
      end
      want = expected_blurs.pop_front();
      if (pix !== want.pixel) begin
        $error("filtered_pixel: expected %0d, actual %0d", want.pixel, pix);
        error_count++;
      end
      if (row !== want.row) begin
        $error("out_row: expected %0d, actual %0d", want.row, row);
        error_count++;
      end
      if (col !== want.col) begin
        $error("out_col: expected %0d, actual %0d", want.col, col);
        error_count++;
      end
      if (fe !== want.last) begin
        $error("frame_end: expected %0d, actual %0d", want.last, fe);
        error_count++;
      end
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  blur_scoreboard sb;

  glb3_in_if  in_if ();
  glb3_out_if out_if ();
  glb3_cfg_if cfg_if ();

  gaussian_blur_3x3_gray u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_blurred(out_if.filtered_pixel, out_if.out_row, out_if.out_col,
                       out_if.frame_end);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.pixel_in <= pix;
    in_if.frame_start <= fs;
    do @(posedge clk); while (!in_if.ready);
    sb.take_pixel(pix, fs);
    @(negedge clk);
  endtask

  // A negative fill value selects random pixel content.
  task automatic send_frame(input int unsigned count, input bit start, input int fill);
    logic [PIX_W-1:0] pix;
    for (int unsigned i = 0; i < count; i++) begin
      if (fill >= 0) begin
        pix = PIX_W'(fill);
      end else begin
        case ($urandom_range(0, 9))
          0: pix = '0;
          1: pix = '1;
          default: pix = PIX_W'($urandom_range(0, 255));
        endcase
      end
      send_pixel(pix, start && i == 0);
    end
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.idx <= idx;
    cfg_if.wdata <= value;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_sizes(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    cfg_write(REG_IMAGE_WIDTH, w);
    cfg_write(REG_IMAGE_HEIGHT, h);
  endtask

  // Border pixels leave no result, so once no result is pending the pipeline is also
  // drained with the output stall turned off.
  task automatic quiesce();
    int unsigned saved;
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    saved = recv_stall_pct;
    recv_stall_pct = 0;
    repeat (4) @(negedge clk);
    recv_stall_pct = saved;
  endtask

  initial begin
    int unsigned           send_modes [4];
    int unsigned           recv_modes [4];
    int unsigned           phase_pixels;
    int unsigned           full;
    int unsigned           count;
    bit                    cut_last;
    bit                    start;
    logic [CFG_DATA_W-1:0] w_val;
    logic [CFG_DATA_W-1:0] h_val;
    sb = new();
    send_modes = '{0, 80, 0, 20};
    recv_modes = '{0, 0, 80, 20};
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.pixel_in = '0;
    in_if.frame_start = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.idx = REG_IMAGE_WIDTH;
    cfg_if.wdata = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Sizes below the minimum clamp to 3 by 3; the second frame relies on the
    // counters wrapping without a frame start.
    write_sizes(12'd1, 12'd2);
    send_frame(9, 1'b1, 255);
    send_frame(9, 1'b0, 0);
    quiesce();

    // Width lowered mid-frame while the column counter is already past it.
    write_sizes(12'd10, 12'd10);
    send_frame(57, 1'b1, -1);
    quiesce();
    cfg_write(REG_IMAGE_WIDTH, 12'd5);
    send_frame(21, 1'b0, -1);
    quiesce();

    // Height lowered mid-frame while the row counter is already past it.
    send_frame(30, 1'b1, -1);
    quiesce();
    cfg_write(REG_IMAGE_HEIGHT, 12'd4);
    send_frame(25, 1'b0, -1);
    quiesce();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_modes[p];
      recv_stall_pct = recv_modes[p];
      phase_pixels = 0;
      cut_last = 1'b1;
      while (phase_pixels < 260) begin
        if (phase_pixels == 0 || $urandom_range(0, 2) == 0) begin
          quiesce();
          if ($urandom_range(0, 19) == 0) w_val = CFG_DATA_W'($urandom_range(0, 2));
          else if ($urandom_range(0, 9) == 0) w_val = CFG_DATA_W'($urandom_range(17, 64));
          else w_val = CFG_DATA_W'($urandom_range(3, 16));
          if ($urandom_range(0, 19) == 0) h_val = CFG_DATA_W'($urandom_range(0, 2));
          else h_val = CFG_DATA_W'($urandom_range(3, 8));
          write_sizes(w_val, h_val);
        end
        full = sb.frame_pixels();
        count = ($urandom_range(0, 6) == 0) ? $urandom_range(1, full - 1) : full;
        start = cut_last || ($urandom_range(0, 5) != 0);
        send_frame(count, start, -1);
        cut_last = (count != full);
        phase_pixels += count;
      end
      quiesce();
    end

    if (sb.error_count == 0) begin
      $display("tb_gaussian_blur_3x3_gray: clean");
    end else begin
      $display("tb_gaussian_blur_3x3_gray: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_gaussian_blur_3x3_gray: errors");
    $finish;
  end

endmodule

[gaussian_blur_3x3_gray.f]
sv/glb3_pkg.sv
sv/glb3_if.sv
sv/glb3_linebuf.sv
sv/glb3_window.sv
sv/glb3_ctrl.sv
sv/gaussian_blur_3x3_gray.sv
bench/tb_gaussian_blur_3x3_gray.sv
